// ===== sv/scsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsd_pkg: shared types and constants of the stress detector
// Sizes, fixed-point constants, register indexes, controller states and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package scsd_pkg;

	localparam int PEAK_SLOTS    = 10;
	localparam int CAL_COUNT_MAX = 4096;

	localparam int SLOT_W   = $clog2(PEAK_SLOTS);
	localparam int CNT_W    = $clog2(CAL_COUNT_MAX + 1);
	localparam int SUM_W    = 12 + $clog2(CAL_COUNT_MAX);
	localparam int DIV_W    = 44;
	localparam int DVSR_W   = 28;
	localparam int DIV_CW   = $clog2(DIV_W + 1);

	localparam logic [31:0] WINDOW_MS   = 32'd60000;
	localparam logic [14:0] PCT_SCALE   = 15'd25600;
	localparam logic [17:0] EMA_K       = 18'd67109;
	localparam int          EMA_SHIFT   = 26;
	localparam logic [27:0] BASE_MAX    = 28'hFFFFFFF;
	localparam logic [9:0]  MS_PER_SEC  = 10'd1000;

	localparam logic [2:0] REG_START_TIME = 3'd0;
	localparam logic [2:0] REG_CAL_SEC    = 3'd1;
	localparam logic [2:0] REG_PEAK_AMP   = 3'd2;
	localparam logic [2:0] REG_STRESS_PCT = 3'd3;
	localparam logic [2:0] REG_PEAK_CNT   = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_BDIV,
		S_MUL,
		S_PSTART,
		S_PDIV,
		S_SCAN,
		S_DONE
	} scsd_state_t;

	typedef struct packed {
		logic load;
		logic cal_acc;
		logic div_base;
		logic set_base;
		logic mul;
		logic div_pct;
		logic set_pct;
		logic pct_zero;
		logic scan;
		logic finish;
	} scsd_cmd_t;

	typedef struct packed {
		logic calib;
		logic need_base;
		logic base_nz;
		logic div_done;
		logic scan_last;
	} scsd_sts_t;

endpackage

// ===== sv/scsd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsd_div: serial restoring divider
// Produces one quotient bit per cycle; done pulses once the quotient is final.
// ----------------------------------------------------------------------------
module scsd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [scsd_pkg::DIV_W-1:0]    dividend,
	input  logic [scsd_pkg::DVSR_W-1:0]   divisor,
	output logic                          done,
	output logic [scsd_pkg::DIV_W-1:0]    quotient
);

	logic [scsd_pkg::DVSR_W-1:0] rem_q;
	logic [scsd_pkg::DIV_W-1:0]  quo_q;
	logic [scsd_pkg::DVSR_W-1:0] dvsr_q;
	logic [scsd_pkg::DIV_CW-1:0] cnt_q;
	logic                        done_q;
	logic [scsd_pkg::DVSR_W:0]   shifted;
	logic [scsd_pkg::DVSR_W:0]   trial;

	assign shifted = {rem_q, quo_q[scsd_pkg::DIV_W-1]};
	assign trial   = shifted - {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= scsd_pkg::DIV_CW'(scsd_pkg::DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == scsd_pkg::DIV_CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[scsd_pkg::DVSR_W]) begin
				rem_q <= trial[scsd_pkg::DVSR_W-1:0];
				quo_q <= {quo_q[scsd_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[scsd_pkg::DVSR_W-1:0];
				quo_q <= {quo_q[scsd_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/scsd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsd_ctrl: sequencing controller
// Steps one request through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
module scsd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 smp_valid,
	output logic                 smp_stall,
	output logic                 res_valid,
	input  logic                 res_stall,
	input  scsd_pkg::scsd_sts_t  sts,
	output scsd_pkg::scsd_cmd_t  cmd
);

	scsd_pkg::scsd_state_t state_q, state_d;
	logic                  res_valid_q;
	logic                  res_free;

	assign res_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scsd_pkg::S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		smp_stall = 1'b1;
		case (state_q)
			scsd_pkg::S_IDLE: begin
				smp_stall = 1'b0;
				if (smp_valid) begin
					cmd.load = 1'b1;
					state_d  = scsd_pkg::S_CHECK;
				end
			end
			scsd_pkg::S_CHECK: begin
				if (sts.calib) begin
					cmd.cal_acc = 1'b1;
					state_d     = scsd_pkg::S_DONE;
				end else if (sts.need_base) begin
					cmd.div_base = 1'b1;
					state_d      = scsd_pkg::S_BDIV;
				end else begin
					state_d = scsd_pkg::S_MUL;
				end
			end
			scsd_pkg::S_BDIV: begin
				if (sts.div_done) begin
					cmd.set_base = 1'b1;
					state_d      = scsd_pkg::S_MUL;
				end
			end
			scsd_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = scsd_pkg::S_PSTART;
			end
			scsd_pkg::S_PSTART: begin
				if (sts.base_nz) begin
					cmd.div_pct = 1'b1;
					state_d     = scsd_pkg::S_PDIV;
				end else begin
					cmd.pct_zero = 1'b1;
					state_d      = scsd_pkg::S_SCAN;
				end
			end
			scsd_pkg::S_PDIV: begin
				if (sts.div_done) begin
					cmd.set_pct = 1'b1;
					state_d     = scsd_pkg::S_SCAN;
				end
			end
			scsd_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = scsd_pkg::S_DONE;
				end
			end
			scsd_pkg::S_DONE: begin
				if (res_free) begin
					cmd.finish = 1'b1;
					state_d    = scsd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = scsd_pkg::S_IDLE;
			end
		endcase
	end

	assign res_valid = res_valid_q;

endmodule

// ===== sv/scsd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsd_dp: detector datapath
// Holds configuration, calibration sums, baseline, peak ring and the result
// register, and carries out the steps the controller commands.
// ----------------------------------------------------------------------------
module scsd_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic [11:0]          sample,
	input  logic [31:0]          time_ms,
	input  scsd_pkg::scsd_cmd_t  cmd,
	output scsd_pkg::scsd_sts_t  sts,
	output logic                 calibrating,
	output logic [27:0]          baseline_q16,
	output logic signed [23:0]   percent_above_q8,
	output logic [3:0]           peaks_in_window,
	output logic                 stress_flag
);

	logic [31:0] start_q;
	logic [9:0]  cal_sec_q;
	logic [11:0] amp_q;
	logic [9:0]  thr_pct_q;
	logic [3:0]  thr_cnt_q;

	logic [11:0] sample_q;
	logic [31:0] time_q;
	logic        calib_q;

	logic [scsd_pkg::SUM_W-1:0]  cal_sum_q;
	logic [scsd_pkg::CNT_W-1:0]  cal_cnt_q;
	logic [27:0]                 baseline_q;
	logic                        ready_q;
	logic [11:0]                 prev_q;
	logic [11:0]                 prev2_q;
	logic [31:0]                 stamps_q [scsd_pkg::PEAK_SLOTS];
	logic [scsd_pkg::SLOT_W-1:0] slot_q;
	logic [scsd_pkg::SLOT_W-1:0] scan_idx_q;
	logic [3:0]                  win_cnt_q;

	logic [43:0]        pct_num_q;
	logic               pct_neg_q;
	logic signed [47:0] ema_prod_q;
	logic signed [23:0] pct_q;

	logic [19:0]        cal_lim;
	logic [31:0]        elapsed;
	logic signed [29:0] delta;
	logic [28:0]        delta_mag;
	logic signed [12:0] diff, pdiff;
	logic               is_peak;
	logic [31:0]        win_lo;
	logic [31:0]        scan_stamp;
	logic               in_win;
	logic signed [47:0] ema_sum;
	logic signed [47:0] ema_step;
	logic signed [30:0] new_base;
	logic               elevated;
	logic               stress;

	logic                           div_start;
	logic [scsd_pkg::DIV_W-1:0]     div_dividend;
	logic [scsd_pkg::DVSR_W-1:0]    div_divisor;
	logic                           div_done;
	logic [scsd_pkg::DIV_W-1:0]     div_quo;

	assign cal_lim = cal_sec_q * scsd_pkg::MS_PER_SEC;
	assign elapsed = time_ms - start_q;

	assign delta     = $signed({2'b00, sample_q, 16'h0000}) - $signed({2'b00, baseline_q});
	assign delta_mag = delta[29] ? 29'(-delta) : delta[28:0];

	assign diff    = $signed({1'b0, sample_q}) - $signed({1'b0, prev_q});
	assign pdiff   = $signed({1'b0, prev_q}) - $signed({1'b0, prev2_q});
	assign is_peak = (pdiff > $signed({1'b0, amp_q}))
		&& ($signed({diff, 1'b0}) < -$signed({2'b00, amp_q}));

	assign win_lo     = (time_q > scsd_pkg::WINDOW_MS) ? time_q - scsd_pkg::WINDOW_MS : 32'd0;
	assign scan_stamp = stamps_q[scan_idx_q];
	assign in_win     = (scan_stamp > win_lo) && (scan_stamp <= time_q);

	assign ema_sum  = ema_prod_q + 48'sd33554432;
	assign ema_step = ema_sum >>> scsd_pkg::EMA_SHIFT;
	assign new_base = $signed({3'b000, baseline_q}) + ema_step[30:0];

	assign elevated = pct_q > $signed({6'b0, thr_pct_q, 8'h00});
	assign stress   = elevated || (win_cnt_q >= thr_cnt_q);

	assign div_start    = cmd.div_base || cmd.div_pct;
	assign div_dividend = cmd.div_base
		? scsd_pkg::DIV_W'({cal_sum_q, 16'h0000}) : pct_num_q;
	assign div_divisor  = cmd.div_base ? scsd_pkg::DVSR_W'(cal_cnt_q) : baseline_q;

	scsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign sts.calib     = calib_q;
	assign sts.need_base = !ready_q && (cal_cnt_q != '0);
	assign sts.base_nz   = baseline_q != '0;
	assign sts.div_done  = div_done;
	assign sts.scan_last = scan_idx_q == scsd_pkg::SLOT_W'(scsd_pkg::PEAK_SLOTS - 1);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= 32'd0;
			cal_sec_q <= 10'd30;
			amp_q     <= 12'd50;
			thr_pct_q <= 10'd20;
			thr_cnt_q <= 4'd3;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				scsd_pkg::REG_START_TIME: start_q   <= cfg_data;
				scsd_pkg::REG_CAL_SEC:    cal_sec_q <= cfg_data[9:0];
				scsd_pkg::REG_PEAK_AMP:   amp_q     <= cfg_data[11:0];
				scsd_pkg::REG_STRESS_PCT: thr_pct_q <= cfg_data[9:0];
				scsd_pkg::REG_PEAK_CNT:   thr_cnt_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Detector state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_sum_q  <= '0;
			cal_cnt_q  <= '0;
			baseline_q <= '0;
			ready_q    <= 1'b0;
			prev_q     <= '0;
			prev2_q    <= '0;
			slot_q     <= '0;
			for (int i = 0; i < scsd_pkg::PEAK_SLOTS; i++) begin
				stamps_q[i] <= '0;
			end
		end else begin
			if (cmd.cal_acc && (cal_cnt_q < scsd_pkg::CNT_W'(scsd_pkg::CAL_COUNT_MAX))) begin
				cal_sum_q <= cal_sum_q + scsd_pkg::SUM_W'(sample_q);
				cal_cnt_q <= cal_cnt_q + 1'b1;
			end
			if (cmd.set_base) begin
				ready_q    <= 1'b1;
				baseline_q <= (div_quo > scsd_pkg::DIV_W'(scsd_pkg::BASE_MAX))
					? scsd_pkg::BASE_MAX : div_quo[27:0];
			end
			if (cmd.mul) begin
				prev2_q <= prev_q;
				prev_q  <= sample_q;
				if (is_peak) begin
					stamps_q[slot_q] <= time_q;
					slot_q <= (slot_q == scsd_pkg::SLOT_W'(scsd_pkg::PEAK_SLOTS - 1))
						? '0 : slot_q + 1'b1;
				end
			end
			if (cmd.finish && !calib_q && !stress && ready_q) begin
				if (new_base < 0) begin
					baseline_q <= '0;
				end else if (new_base > $signed({3'b000, scsd_pkg::BASE_MAX})) begin
					baseline_q <= scsd_pkg::BASE_MAX;
				end else begin
					baseline_q <= new_base[27:0];
				end
			end
		end
	end

	// Per-request working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
			time_q   <= time_ms;
			calib_q  <= elapsed < {12'h000, cal_lim};
		end
		if (cmd.mul) begin
			pct_num_q  <= delta_mag * scsd_pkg::PCT_SCALE;
			pct_neg_q  <= delta[29];
			ema_prod_q <= delta * $signed(scsd_pkg::EMA_K);
			scan_idx_q <= '0;
			win_cnt_q  <= '0;
		end
		if (cmd.pct_zero) begin
			pct_q <= '0;
		end
		if (cmd.set_pct) begin
			if (pct_neg_q) begin
				pct_q <= (div_quo > 44'd8388608) ? 24'sh800000 : 24'(-div_quo[23:0]);
			end else begin
				pct_q <= (div_quo > 44'd8388607) ? 24'sh7FFFFF : div_quo[23:0];
			end
		end
		if (cmd.scan) begin
			if (!sts.scan_last) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (in_win && (win_cnt_q != 4'hF)) begin
				win_cnt_q <= win_cnt_q + 1'b1;
			end
		end
		if (cmd.finish) begin
			calibrating      <= calib_q;
			baseline_q16     <= calib_q ? 28'd0 : baseline_q;
			percent_above_q8 <= calib_q ? 24'sd0 : pct_q;
			peaks_in_window  <= calib_q ? 4'd0 : win_cnt_q;
			stress_flag      <= !calib_q && stress;
		end
	end

endmodule

// ===== sv/skin_conductance_stress_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skin_conductance_stress_detector_top: skin conductance stress detector
// Calibrates a baseline, then reports level above baseline, recent peaks and
// a stress flag for every sample request.
// ----------------------------------------------------------------------------
// One request is processed at a time and yields exactly one result. A sample
// that falls inside the calibration phase gives its result once the check and
// done states have passed, and the next request can be accepted as soon as the
// controller is back in idle. With a nonzero baseline the serial divider first
// forms the percent-above-baseline quotient, and the peak window count then
// walks the stamp ring one slot per cycle. With no baseline the divider is
// skipped. The very first sample after calibration also runs the divider for
// the baseline, since the same divider first turns the calibration sum into
// the mean baseline. A finished result waits while the result register still
// holds an earlier result that the consumer stalls. The result register lets
// the next request be accepted while a previous result is still held by a
// stalled consumer. Configuration writes take effect on the clock edge at
// which the write enable is high and should be made only while the block is
// idle.
// ----------------------------------------------------------------------------
module skin_conductance_stress_detector_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               smp_valid,
	output logic               smp_stall,
	input  logic [11:0]        sample,
	input  logic [31:0]        time_ms,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               calibrating,
	output logic [27:0]        baseline_q16,
	output logic signed [23:0] percent_above_q8,
	output logic [3:0]         peaks_in_window,
	output logic               stress_flag
);

	// Apart from the sample and result handshakes, the controller sees only the
	// status group and drives only the command group; everything stored about the signal lives in the datapath.
	scsd_pkg::scsd_cmd_t cmd;
	scsd_pkg::scsd_sts_t sts;

	scsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds configuration, baseline, peak ring and result fields.
	scsd_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.sample           (sample),
		.time_ms          (time_ms),
		.cmd              (cmd),
		.sts              (sts),
		.calibrating      (calibrating),
		.baseline_q16     (baseline_q16),
		.percent_above_q8 (percent_above_q8),
		.peaks_in_window  (peaks_in_window),
		.stress_flag      (stress_flag)
	);

endmodule

// ===== sv/scsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsd_checker: port-level checks of the stress detector
// Watches the top-level ports and flags result handshake or content slips.
// ----------------------------------------------------------------------------
module scsd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input logic               calibrating,
	input logic [27:0]        baseline_q16,
	input logic signed [23:0] percent_above_q8,
	input logic [3:0]         peaks_in_window,
	input logic               stress_flag
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(baseline_q16) && $stable(percent_above_q8)
			&& $stable(peaks_in_window) && $stable(stress_flag)
			&& $stable(calibrating))
		else $error("result changed while stalled");

	a_cal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && calibrating |-> baseline_q16 == '0 && percent_above_q8 == '0
			&& peaks_in_window == '0 && !stress_flag)
		else $error("calibration result carries nonzero fields");

	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> peaks_in_window <= 4'(scsd_pkg::PEAK_SLOTS))
		else $error("peak count exceeds ring size");

endmodule

bind skin_conductance_stress_detector_top scsd_checker u_scsd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res_valid),
	.res_stall        (res_stall),
	.calibrating      (calibrating),
	.baseline_q16     (baseline_q16),
	.percent_above_q8 (percent_above_q8),
	.peaks_in_window  (peaks_in_window),
	.stress_flag      (stress_flag)
);
